// ===== rtl/core/i2cw_pkg.sv =====
// Shared types and constants for the three-byte I2C write master.
package i2cw_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEV_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT  = 1'b1;

    localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
    localparam logic [7:0] TIMEOUT_RESET  = 8'd250;

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_START_FALL  = 4'd1;
    localparam logic [3:0] PH_START_CLAMP = 4'd2;
    localparam logic [3:0] PH_BIT_SETUP   = 4'd3;
    localparam logic [3:0] PH_BIT_HIGH    = 4'd4;
    localparam logic [3:0] PH_ACK_RELEASE = 4'd5;
    localparam logic [3:0] PH_ACK_RISE    = 4'd6;
    localparam logic [3:0] PH_ACK_POLL    = 4'd7;
    localparam logic [3:0] PH_STOP_LOW    = 4'd8;
    localparam logic [3:0] PH_STOP_RISE   = 4'd9;
    localparam logic [3:0] PH_STOP_END    = 4'd10;

    localparam logic [1:0] LAST_BYTE_INDEX = 2'd2;

    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] byte_index;
        logic [2:0] bit_count;
        logic [7:0] shift;
        logic [7:0] poll_count;
        logic [7:0] held_control;
        logic [7:0] held_data;
        logic       error_flag;
        logic       scl;
        logic       sda;
        logic       drive;
    } i2cw_state_t;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] timeout;
    } i2cw_cfg_t;

endpackage

// ===== rtl/core/i2cw_cfg.sv =====
// Configuration registers: device address byte and acknowledge timeout.
module i2cw_cfg
    import i2cw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output i2cw_cfg_t            cfg_out
);

    logic [7:0] dev_addr_reg;
    logic [7:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_DEV_ADDR: dev_addr_reg <= cfg_data;
                CFG_IDX_TIMEOUT:  timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_out.dev_addr = dev_addr_reg;
    assign cfg_out.timeout  = timeout_reg;

endmodule

// ===== rtl/core/i2cw_step.sv =====
// Next-state logic of the bus sequencer for one accepted word.
module i2cw_step
    import i2cw_pkg::*;
(
    input  i2cw_state_t state,
    input  i2cw_cfg_t   cfg,
    input  logic        action,
    input  logic [7:0]  control_byte,
    input  logic [7:0]  data_byte,
    input  logic        sda_in,
    output i2cw_state_t state_next,
    output logic        done
);

    logic [2:0] bit_count_inc;
    logic [1:0] byte_index_inc;

    assign bit_count_inc  = state.bit_count + 3'd1;
    assign byte_index_inc = state.byte_index + 2'd1;

    always_comb begin
        state_next = state;
        done       = 1'b0;
        if (action) begin
            if (state.phase == PH_IDLE) begin
                state_next.held_control = control_byte;
                state_next.held_data    = data_byte;
                state_next.error_flag   = 1'b0;
                state_next.byte_index   = 2'd0;
                state_next.bit_count    = 3'd0;
                state_next.poll_count   = 8'd0;
                state_next.scl          = 1'b1;
                state_next.sda          = 1'b1;
                state_next.drive        = 1'b1;
                state_next.phase        = PH_START_FALL;
            end
        end else begin
            unique case (state.phase)
                PH_IDLE: ;
                PH_START_FALL: begin
                    state_next.sda   = 1'b0;
                    state_next.phase = PH_START_CLAMP;
                end
                PH_START_CLAMP: begin
                    state_next.scl       = 1'b0;
                    state_next.shift     = cfg.dev_addr;
                    state_next.bit_count = 3'd0;
                    state_next.phase     = PH_BIT_SETUP;
                end
                PH_BIT_SETUP: begin
                    state_next.scl   = 1'b0;
                    state_next.drive = 1'b1;
                    state_next.sda   = state.shift[7];
                    state_next.phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    state_next.scl       = 1'b1;
                    state_next.shift     = {state.shift[6:0], 1'b0};
                    state_next.bit_count = bit_count_inc;
                    state_next.phase     = (bit_count_inc == 3'd0) ? PH_ACK_RELEASE
                                                                   : PH_BIT_SETUP;
                end
                PH_ACK_RELEASE: begin
                    state_next.scl   = 1'b0;
                    state_next.drive = 1'b0;
                    state_next.sda   = 1'b1;
                    state_next.phase = PH_ACK_RISE;
                end
                PH_ACK_RISE: begin
                    state_next.scl        = 1'b1;
                    state_next.poll_count = 8'd0;
                    state_next.phase      = PH_ACK_POLL;
                end
                PH_ACK_POLL: begin
                    if (!sda_in) begin
                        state_next.scl = 1'b0;
                        if (state.byte_index >= LAST_BYTE_INDEX) begin
                            state_next.phase = PH_STOP_LOW;
                        end else begin
                            state_next.byte_index = byte_index_inc;
                            state_next.shift      = (byte_index_inc == 2'd1) ?
                                                    state.held_control : state.held_data;
                            state_next.bit_count  = 3'd0;
                            state_next.phase      = PH_BIT_SETUP;
                        end
                    end else if (state.poll_count >= cfg.timeout) begin
                        state_next.error_flag = 1'b1;
                        state_next.scl        = 1'b0;
                        state_next.phase      = PH_STOP_LOW;
                    end else begin
                        state_next.poll_count = state.poll_count + 8'd1;
                    end
                end
                PH_STOP_LOW: begin
                    state_next.scl   = 1'b0;
                    state_next.drive = 1'b1;
                    state_next.sda   = 1'b0;
                    state_next.phase = PH_STOP_RISE;
                end
                PH_STOP_RISE: begin
                    state_next.scl   = 1'b1;
                    state_next.phase = PH_STOP_END;
                end
                PH_STOP_END: begin
                    state_next.sda   = 1'b1;
                    done             = 1'b1;
                    state_next.phase = PH_IDLE;
                end
                default: begin
                    state_next.scl   = 1'b1;
                    state_next.sda   = 1'b1;
                    state_next.drive = 1'b1;
                    state_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/i2c_three_byte_write_master_core.sv =====
// Top level of the three-byte I2C write master with stream ports.
//
// Every input word on the s_ channel is either a start request (s_tuser high),
// which latches the control and data bytes, or one tick of bus time (s_tuser
// low), which moves the bus by one SCL half-phase and samples sda_in.
// Every accepted word yields exactly one status word on the m_ channel with
// the SCL level, the SDA level, the SDA drive enable and the busy, done and
// acknowledge-error flags. A start that arrives while busy is ignored.
// The result is registered and appears in the cycle after the word is
// accepted; the sequencer state and the output register both update in the
// accepting cycle, so one word is taken per cycle while the receiver keeps up.
// When the receiver stalls, the result stays in the output register and
// s_tready falls until it is taken, so no word is lost.
// The configuration channel writes the device address byte (index 0) and the
// acknowledge timeout (index 1); it is always ready and should be used only
// while no transaction is running.
// Synchronous reset returns the sequencer to idle with SCL and SDA high and
// SDA driven, restores the register defaults and empties the output register.
module i2c_three_byte_write_master_core
    import i2cw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // control_byte[7:0], data_byte[15:8], sda_in[16], zero fill [23:17]
    input  logic [23:0]          s_tdata,
    // action[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
    // ack_error[5], zero fill [7:6]
    output logic [7:0]           m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    i2cw_cfg_t   cfg;
    i2cw_state_t state_reg;
    i2cw_state_t state_next;
    logic        done_next;
    logic        accept;
    logic        m_tvalid_reg;
    logic [5:0]  result_reg;

    i2cw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    i2cw_step u_step (
        .state        (state_reg),
        .cfg          (cfg),
        .action       (s_tuser),
        .control_byte (s_tdata[7:0]),
        .data_byte    (s_tdata[15:8]),
        .sda_in       (s_tdata[16]),
        .state_next   (state_next),
        .done         (done_next)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.byte_index   <= 2'd0;
            state_reg.bit_count    <= 3'd0;
            state_reg.shift        <= 8'd0;
            state_reg.poll_count   <= 8'd0;
            state_reg.held_control <= 8'd0;
            state_reg.held_data    <= 8'd0;
            state_reg.error_flag   <= 1'b0;
            state_reg.scl          <= 1'b1;
            state_reg.sda          <= 1'b1;
            state_reg.drive        <= 1'b1;
            m_tvalid_reg           <= 1'b0;
        end else begin
            if (accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= {state_next.error_flag, done_next,
                           (state_next.phase != PH_IDLE), state_next.drive,
                           state_next.sda, state_next.scl};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg};

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[3])
        else $error("done reported while still busy");

    a_start_enters_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser && (state_reg.phase == PH_IDLE)
        |=> state_reg.phase == PH_START_FALL)
        else $error("start from idle did not begin the start condition");

    a_release_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.drive |-> (state_reg.phase == PH_ACK_RISE)
                          || (state_reg.phase == PH_ACK_POLL)
                          || (state_reg.phase == PH_BIT_SETUP)
                          || (state_reg.phase == PH_STOP_LOW))
        else $error("SDA released outside the acknowledge window");

    a_error_to_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.error_flag) |-> state_reg.phase == PH_STOP_LOW)
        else $error("acknowledge timeout did not go to the stop");

endmodule
